// ----- rtl/rc4_pkg.sv -----
// Shared definitions for the RC4 stream cipher block.
// Holds widths, register codes and the controller/datapath command and status structs.
// No dependencies.
package rc4_pkg;

	// byte and table sizes
	localparam int BYTE_W       = 8;
	localparam int PERM_N       = 256;
	localparam int LEN_W        = 9;
	localparam int KEY_DEPTH_DEF = 256;

	// configuration port
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 1'b0;
	localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 9'd16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic key_load;   // store an accepted key byte
		logic data_load;  // take a keyed data byte, advance i, read S[i]
		logic pass_load;  // send an unkeyed data byte straight out
		logic restart;    // clear pointer, j and key index before a schedule
		logic fill;       // write the identity entry at the pointer
		logic read_ptr;   // read S[ptr] and the key byte
		logic read_j;     // form new j and read S[j]
		logic mix_key;    // add the key byte into j
		logic write_ptr;  // write S[ptr] = S[j], read the keystream entry
		logic write_j;    // write S[j] = S[ptr]
		logic step_ptr;   // advance the schedule pointer and key index
		logic emit;       // load the keystream result into the output register
	} rc4_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic keyed;      // a complete key is loaded
		logic key_done;   // the key byte on offer completes the key
		logic ptr_last;   // pointer at the final table entry
		logic msg_end;    // current data byte closes a message
		logic out_free;   // output register can take a result this cycle
	} rc4_sts_t;

endpackage

// ----- rtl/rc4_ctrl.sv -----
// Controller state machine for the RC4 stream cipher.
// Sequences identity fill, key scheduling and keystream steps; depends on rc4_pkg.
module rc4_ctrl
	import rc4_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     mode,
	output logic     item_stall,
	input  rc4_sts_t sts,
	output rc4_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_FILL   = 9'b000000010,
		ST_KSA_RD = 9'b000000100,
		ST_KSA_J  = 9'b000001000,
		ST_KSA_WN = 9'b000010000,
		ST_KSA_WJ = 9'b000100000,
		ST_PRG_J  = 9'b001000000,
		ST_PRG_WI = 9'b010000000,
		ST_PRG_WJ = 9'b100000000
	} rc4_state_t;

	rc4_state_t state_q;
	rc4_state_t state_next;
	logic       accept;

	// take requests only when idle; hold data while the output is blocked
	assign item_stall = (state_q != ST_IDLE) || (mode && !sts.out_free);
	assign accept     = item_valid && !item_stall;

	// next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!mode) begin
						cmd.key_load = 1'b1;
						if (sts.key_done) begin
							cmd.restart = 1'b1;
							state_next  = ST_FILL;
						end
					end else if (sts.keyed) begin
						cmd.data_load = 1'b1;
						state_next    = ST_PRG_J;
					end else begin
						cmd.pass_load = 1'b1;
					end
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.ptr_last) begin
					state_next = ST_KSA_RD;
				end
			end
			ST_KSA_RD: begin
				cmd.read_ptr = 1'b1;
				state_next   = ST_KSA_J;
			end
			ST_KSA_J: begin
				cmd.read_j  = 1'b1;
				cmd.mix_key = 1'b1;
				state_next  = ST_KSA_WN;
			end
			ST_KSA_WN: begin
				cmd.write_ptr = 1'b1;
				state_next    = ST_KSA_WJ;
			end
			ST_KSA_WJ: begin
				cmd.write_j  = 1'b1;
				cmd.step_ptr = 1'b1;
				state_next   = sts.ptr_last ? ST_IDLE : ST_KSA_RD;
			end
			ST_PRG_J: begin
				cmd.read_j = 1'b1;
				state_next = ST_PRG_WI;
			end
			ST_PRG_WI: begin
				cmd.write_ptr = 1'b1;
				state_next    = ST_PRG_WJ;
			end
			ST_PRG_WJ: begin
				// repeat the write while the output is blocked; it is idempotent
				cmd.write_j = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.msg_end) begin
						cmd.restart = 1'b1;
						state_next  = ST_FILL;
					end else begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

`ifndef SYNTHESIS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRG_WJ && !sts.out_free) |=> (state_q == ST_PRG_WJ))
		else $error("keystream step left before its result was taken");
	a_fill_to_ksa: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && sts.ptr_last) |=> (state_q == ST_KSA_RD))
		else $error("identity fill did not hand over to key scheduling");
	a_key_starts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.key_load && sts.key_done) |=> (state_q == ST_FILL))
		else $error("completed key did not start the schedule");
`endif

endmodule

// ----- rtl/rc4_dp.sv -----
// Datapath for the RC4 stream cipher: permutation and key memories, indices, output register.
// Driven by rc4_ctrl through rc4_cmd_t; depends on rc4_pkg.
module rc4_dp
	import rc4_pkg::*;
#(
	parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rc4_cmd_t          cmd,
	output rc4_sts_t          sts,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              message_end,
	input  logic              cfg_wr,
	input  logic [LEN_W-1:0]  cfg_data,
	output logic [LEN_W-1:0]  key_length,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [BYTE_W-1:0] result_byte,
	output logic              unkeyed
);

	localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	// memories
	logic [BYTE_W-1:0] perm_mem [PERM_N];
	logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];

	// control registers
	logic [LEN_W-1:0]  klen_q;
	logic [LEN_W-1:0]  loaded_q;
	logic              keyed_q;
	logic [BYTE_W-1:0] ptr_q;
	logic [BYTE_W-1:0] j_q;
	logic [KAW-1:0]    kidx_q;
	logic              last_q;
	logic              res_valid_q;

	// payload registers
	logic [BYTE_W-1:0] data_q;
	logic [BYTE_W-1:0] s_q;
	logic [BYTE_W-1:0] rda_q;
	logic [BYTE_W-1:0] rdb_q;
	logic [BYTE_W-1:0] kb_q;
	logic              hit_i_q;
	logic              hit_j_q;
	logic [BYTE_W-1:0] res_byte_q;
	logic              res_unk_q;

	logic [LEN_W-1:0]  eff_len;
	logic              key_restart;
	logic [LEN_W-1:0]  key_count;
	logic [KAW-1:0]    key_waddr;
	logic [KAW-1:0]    kidx_next;
	logic [BYTE_W-1:0] j_next;
	logic [BYTE_W-1:0] rd_addr;
	logic [BYTE_W-1:0] ks_addr;
	logic              wr_en;
	logic [BYTE_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [BYTE_W-1:0] keystream;

	// clamp the key length into 1..KEY_DEPTH
	always_comb begin
		if (klen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (klen_q > LEN_W'(KEY_DEPTH)) begin
			eff_len = LEN_W'(KEY_DEPTH);
		end else begin
			eff_len = klen_q;
		end
	end

	// key loading: a byte after a full key starts a new key at position 0
	assign key_restart = keyed_q || (loaded_q >= eff_len);
	assign key_count   = key_restart ? LEN_W'(1) : loaded_q + LEN_W'(1);
	assign key_waddr   = key_restart ? '0 : loaded_q[KAW-1:0];
	assign kidx_next   = ((LEN_W'(kidx_q) + LEN_W'(1)) == eff_len) ? '0 : kidx_q + KAW'(1);

	// index arithmetic and memory addressing
	assign j_next    = j_q + rda_q + (cmd.mix_key ? kb_q : '0);
	assign rd_addr   = cmd.read_j ? j_next : (cmd.data_load ? ptr_q + 8'd1 : ptr_q);
	assign ks_addr   = s_q + rda_q;
	assign wr_en     = cmd.fill || cmd.write_ptr || cmd.write_j;
	assign wr_addr   = cmd.write_j ? j_q : ptr_q;
	assign wr_data   = cmd.fill ? ptr_q : (cmd.write_ptr ? rda_q : s_q);

	// the keystream read sees the table before the swap: forward swapped entries
	assign keystream = hit_j_q ? s_q : (hit_i_q ? rda_q : rdb_q);

	// status
	assign sts.keyed    = keyed_q;
	assign sts.key_done = key_count >= eff_len;
	assign sts.ptr_last = (ptr_q == {BYTE_W{1'b1}});
	assign sts.msg_end  = last_q;
	assign sts.out_free = !res_valid_q || !result_stall;

	assign key_length   = klen_q;
	assign result_valid = res_valid_q;
	assign result_byte  = res_byte_q;
	assign unkeyed      = res_unk_q;

	// key length, load count and keyed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q   <= KEY_LENGTH_RESET;
			loaded_q <= '0;
			keyed_q  <= 1'b0;
		end else if (cfg_wr) begin
			klen_q   <= cfg_data;
			loaded_q <= '0;
			keyed_q  <= 1'b0;
		end else if (cmd.key_load) begin
			loaded_q <= key_count;
			keyed_q  <= sts.key_done;
		end
	end

	// pointer (schedule counter or i), j and key index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			j_q    <= '0;
			kidx_q <= '0;
		end else if (cmd.restart) begin
			ptr_q  <= '0;
			j_q    <= '0;
			kidx_q <= '0;
		end else begin
			if (cmd.fill || cmd.step_ptr || cmd.data_load) begin
				ptr_q <= ptr_q + 8'd1;
			end
			if (cmd.read_j) begin
				j_q <= j_next;
			end else if (cmd.step_ptr && sts.ptr_last) begin
				j_q <= '0;
			end
			if (cmd.step_ptr) begin
				kidx_q <= kidx_next;
			end
		end
	end

	// message end flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.data_load) begin
				last_q <= message_end;
			end
			if (cmd.emit || cmd.pass_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// permutation memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
		if (cmd.read_ptr || cmd.read_j || cmd.data_load) begin
			rda_q <= perm_mem[rd_addr];
		end
		if (cmd.write_ptr) begin
			rdb_q   <= perm_mem[ks_addr];
			hit_i_q <= (ks_addr == ptr_q);
			hit_j_q <= (ks_addr == j_q);
		end
	end

	// key memory: write on load, registered read during scheduling
	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_mem[key_waddr] <= byte_value;
		end
		if (cmd.read_ptr) begin
			kb_q <= key_mem[kidx_q];
		end
	end

	// data byte, S[ptr] hold and output payload
	always_ff @(posedge clk) begin
		if (cmd.data_load) begin
			data_q <= byte_value;
		end
		if (cmd.read_j) begin
			s_q <= rda_q;
		end
		if (cmd.pass_load) begin
			res_byte_q <= byte_value;
			res_unk_q  <= 1'b1;
		end else if (cmd.emit) begin
			res_byte_q <= data_q ^ keystream;
			res_unk_q  <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.pass_load) |-> sts.out_free)
		else $error("result loaded over one not yet taken");
	a_sched_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_ptr && sts.ptr_last) |=> (ptr_q == '0 && j_q == '0))
		else $error("indices not cleared at end of key schedule");
	a_keyed_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.key_load && sts.key_done && !cfg_wr) |=> keyed_q)
		else $error("completed key not marked as keyed");
`endif

endmodule

// ----- rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher, one byte per request. Key bytes (mode 0) are stored in turn; the
// byte that completes the key starts a key schedule (identity fill of the permutation
// memory, then 256 mixing steps on its single write port), during which no request is
// taken; configuration writes are still accepted. A keyed data byte (mode 1) goes through
// accept with read of S[i], read of S[j], write of S[i] with the keystream read, and
// write of S[j] with the result loaded into the output register once that is free.
// A data byte with message_end set is followed by the same schedule from the stored key.
// Data before a complete key returns unchanged with unkeyed set. Writing key_length (APB,
// address 0) discards any partly or fully loaded key.
module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              mode,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic              message_end,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output logic [BYTE_W-1:0] result_byte,
	output logic              unkeyed
);

	rc4_cmd_t         cmd;
	rc4_sts_t         sts;
	logic             reg_hit;
	logic             cfg_wr;
	logic [LEN_W-1:0] key_length;

	// decode the single register
	assign reg_hit = (paddr[ADDR_W-1 -: REG_IDX_W] == REG_KEY_LENGTH);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(key_length) : '0;

	rc4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	rc4_dp #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.byte_value   (byte_value),
		.message_end  (message_end),
		.cfg_wr       (cfg_wr),
		.cfg_data     (pwdata[LEN_W-1:0]),
		.key_length   (key_length),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_byte  (result_byte),
		.unkeyed      (unkeyed)
	);

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the RC4 stream cipher: directed table, then random key/message traffic.
// Predicts every result with its own keystream model and checks it on the result channel.
// Depends on rc4_pkg and rc4_stream_cipher.
module tb
	import rc4_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam bit MODE_KEY  = 1'b0;
	localparam bit MODE_DATA = 1'b1;

	localparam logic [ADDR_W-1:0] KEY_LEN_ADDR = ADDR_W'(4 * int'(REG_KEY_LENGTH));
	localparam int KEY_SLOTS   = KEY_DEPTH_DEF;
	localparam int SCHED_WAIT  = 1400;
	localparam int RAND_ITEMS  = 1450;
	localparam int CALM_ITEMS  = 150;
	localparam int LIMIT_CYCLES = 6000000;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		bit          md;
		byte_t       val;
		bit          last;
		bit          typed;     // expected result is the byte itself, unkeyed
		logic [31:0] cfg_val;
	} row_t;

	typedef struct packed {
		byte_t rb;
		logic  unk;
	} cipher_out_t;

	// ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic              mode = 1'b0;
	byte_t             byte_value = '0;
	logic              message_end = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	byte_t             result_byte;
	logic              unkeyed;

	// keystream model state
	byte_t        perm_s [PERM_N];
	byte_t        key_mem [KEY_SLOTS];
	byte_t        gen_i;
	byte_t        gen_j;
	int unsigned  key_count;
	bit           have_key;
	logic [LEN_W-1:0] key_len_reg;

	cipher_out_t  pending_out [$];
	row_t         dir_rows [$];
	int           fails;
	int           cycles = 0;
	int           reqs_sent;
	bit           calm;
	bit           gaps_on;
	int           stall_left = 0;

	rc4_stream_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .byte_value(byte_value), .message_end(message_end),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_byte(result_byte), .unkeyed(unkeyed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// clamp the programmed key length into 1..KEY_SLOTS
	function automatic int unsigned eff_key_len();
		if (key_len_reg == 0)
			return 1;
		if (key_len_reg > KEY_SLOTS)
			return KEY_SLOTS;
		return 32'(key_len_reg);
	endfunction

	// rebuild the permutation from the stored key and clear both indices
	function automatic void run_key_schedule();
		int unsigned len;
		byte_t jj;
		byte_t t;
		len = eff_key_len();
		jj = '0;
		for (int n = 0; n < PERM_N; n++)
			perm_s[n] = byte_t'(n);
		for (int n = 0; n < PERM_N; n++) begin
			jj = jj + perm_s[n] + key_mem[n % len];
			t = perm_s[n];
			perm_s[n] = perm_s[jj];
			perm_s[jj] = t;
		end
		gen_i = '0;
		gen_j = '0;
	endfunction

	// advance the model by one request; returns 1 when a result byte follows
	function automatic bit cipher_step(input bit md, input byte_t val, input bit last,
			output byte_t rb, output bit ru);
		int unsigned len;
		byte_t t;
		byte_t idx;
		len = eff_key_len();
		rb = val;
		ru = 1'b1;
		if (md == MODE_KEY) begin
			if (have_key || key_count >= len) begin
				have_key = 1'b0;
				key_count = 0;
			end
			key_mem[key_count % KEY_SLOTS] = val;
			key_count++;
			if (key_count >= len) begin
				run_key_schedule();
				have_key = 1'b1;
			end
			return 1'b0;
		end
		if (!have_key)
			return 1'b1;
		gen_i = gen_i + 8'd1;
		gen_j = gen_j + perm_s[gen_i];
		t = perm_s[gen_i];
		perm_s[gen_i] = perm_s[gen_j];
		perm_s[gen_j] = t;
		idx = perm_s[gen_i] + perm_s[gen_j];
		rb = val ^ perm_s[idx];
		ru = 1'b0;
		if (last)
			run_key_schedule();
		return 1'b1;
	endfunction

	function automatic row_t mk_row(input row_kind_t kind, input bit md, input byte_t val,
			input bit last, input bit typed, input logic [31:0] cfg_val);
		row_t r;
		r.kind = kind;
		r.md = md;
		r.val = val;
		r.last = last;
		r.typed = typed;
		r.cfg_val = cfg_val;
		return r;
	endfunction

	// offer one request; called and returning at a falling edge
	task automatic send_req(input bit md, input byte_t val, input bit last, input bit typed);
		bit has;
		byte_t rb;
		bit ru;
		if ($urandom_range(0, 29) == 0)
			gaps_on = !gaps_on;
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= md;
		byte_value <= val;
		message_end <= last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		has = cipher_step(md, val, last, rb, ru);
		if (has) begin
			if (typed)
				pending_out.push_back('{val, 1'b1});
			else
				pending_out.push_back('{rb, ru});
		end
		reqs_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every expected result has arrived
	task automatic hold_until_drained();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_out.size() != 0)
			@(negedge clk);
	endtask

	// drain and then wait out a possible key schedule
	task automatic settle();
		hold_until_drained();
		repeat (SCHED_WAIT) @(negedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= KEY_LEN_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		if (wr) begin
			key_len_reg = wdata[LEN_W-1:0];
			key_count = 0;
			have_key = 1'b0;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// program key_length while idle, then read it back
	task automatic set_key_length(input logic [31:0] v);
		logic [DATA_W-1:0] rd;
		settle();
		apb_xfer(1'b1, v, rd);
		apb_xfer(1'b0, '0, rd);
		if (rd !== DATA_W'(v[LEN_W-1:0])) begin
			$error("prdata: expected %0h, actual %0h", v[LEN_W-1:0], rd);
			fails++;
		end
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver stalls in random bursts while traffic is not calm
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each delivered result with the oldest expectation
	always @(posedge clk) begin : result_check
		cipher_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_out.size() == 0) begin
				$error("result_byte: expected none, actual %0h", result_byte);
				fails++;
			end else begin
				want = pending_out.pop_front();
				if (result_byte !== want.rb) begin
					$error("result_byte: expected %0h, actual %0h", want.rb, result_byte);
					fails++;
				end
				if (unkeyed !== want.unk) begin
					$error("unkeyed: expected %0b, actual %0b", want.unk, unkeyed);
					fails++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned klen;
		int unsigned eff;
		int unsigned nmsg;
		int unsigned mlen;
		int unsigned part;
		int unsigned pick;
		int unsigned big_left;
		int unsigned target;
		bit first_phase;

		key_len_reg = KEY_LENGTH_RESET;
		key_count = 0;
		have_key = 1'b0;
		gen_i = '0;
		gen_j = '0;
		fails = 0;
		reqs_sent = 0;
		calm = 1'b0;
		gaps_on = 1'b1;

		// directed table: unkeyed pass-through, length clamps, rekeying, message restarts
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h00, 1'b0, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'hFF, 1'b1, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'hFF, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h5A, 1'b0, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_CFG, MODE_KEY,  8'h00, 1'b0, 1'b0, 32'd0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'hA5, 1'b0, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'h00, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h00, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'hFF, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h3C, 1'b1, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h00, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'hFF, 1'b1, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h12, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_CFG, MODE_KEY,  8'h00, 1'b0, 1'b0, 32'd3));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'h4B, 1'b1, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'h65, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'h79, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h50, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h6C, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h61, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h69, 1'b1, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_KEY,  8'h01, 1'b0, 1'b0, 0));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h77, 1'b0, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_CFG, MODE_KEY,  8'h00, 1'b0, 1'b0, 32'd511));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h33, 1'b1, 1'b1, 0));
		dir_rows.push_back(mk_row(ROW_CFG, MODE_KEY,  8'h00, 1'b0, 1'b0, 32'd256));
		dir_rows.push_back(mk_row(ROW_REQ, MODE_DATA, 8'h00, 1'b0, 1'b1, 0));

		// hold reset, then release it
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG)
				set_key_length(dir_rows[r].cfg_val);
			else
				send_req(dir_rows[r].md, dir_rows[r].val, dir_rows[r].last, dir_rows[r].typed);
		end

		// random phases: program a length, load a key, run messages with some broken traffic
		target = reqs_sent + RAND_ITEMS;
		big_left = 2;
		first_phase = 1'b1;
		while (reqs_sent < target) begin
			pick = $urandom_range(0, 15);
			if (first_phase) begin
				klen = 256;
				first_phase = 1'b0;
			end else if (pick == 0) begin
				klen = 0;
			end else if (pick == 1 && big_left != 0) begin
				klen = $urandom_range(257, 511);
				big_left--;
			end else if (pick < 10) begin
				klen = $urandom_range(1, 8);
			end else begin
				klen = $urandom_range(9, 40);
			end
			set_key_length(($urandom() << LEN_W) | klen);
			eff = (klen == 0) ? 1 : (klen > KEY_SLOTS) ? KEY_SLOTS : klen;

			// unkeyed data ahead of the key
			repeat ($urandom_range(0, 2))
				send_req(MODE_DATA, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
			for (int k = 0; k < eff; k++)
				send_req(MODE_KEY, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);

			nmsg = $urandom_range(2, 8);
			for (int m = 0; m < nmsg && reqs_sent < target; m++) begin
				calm = (reqs_sent + CALM_ITEMS >= target);
				pick = $urandom_range(0, 9);
				if (pick == 0 && eff > 1) begin
					// partial key, data in the gap, then finish it
					part = $urandom_range(1, eff - 1);
					for (int k = 0; k < part; k++)
						send_req(MODE_KEY, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
					repeat ($urandom_range(1, 2))
						send_req(MODE_DATA, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
					for (int k = part; k < eff; k++)
						send_req(MODE_KEY, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
				end else if (pick == 1) begin
					// replace a complete key
					for (int k = 0; k < eff; k++)
						send_req(MODE_KEY, byte_t'($urandom()), 1'($urandom_range(0, 1)), 1'b0);
				end else if (pick == 2 && !calm) begin
					hold_until_drained();
				end
				mlen = $urandom_range(1, 20);
				for (int b = 0; b < mlen; b++)
					send_req(MODE_DATA, byte_t'($urandom()),
						(b == mlen - 1) ? ($urandom_range(0, 7) != 0) : 1'b0, 1'b0);
			end
		end
		calm = 1'b1;

		settle();
		if (fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- rc4_stream_cipher.f -----
rtl/rc4_pkg.sv
rtl/rc4_ctrl.sv
rtl/rc4_dp.sv
rtl/rc4_stream_cipher.sv
test/tb.sv
